@@ rtl/tfn_pkg.sv @@
// shared widths and types for the triangle face normal pipeline
package tfn_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = 20;
  localparam int OUT_W            = 16;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int BL_W    = $clog2(MAG_W + 1);
  localparam int SQ_W    = 2 * NORM_BITS;
  localparam int SUM_W   = SQ_W + 2;
  localparam int X_W     = SUM_W + NORM_BITS + ((SUM_W + NORM_BITS) % 2);
  localparam int ROOT_W  = X_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int RT_SHIFT = NORM_BITS / 2;
  localparam int Q_W     = NORMAL_FRAC_BITS + 1;
  localparam int DREM_W  = ROOT_W + Q_W;

  // per-item side data carried alongside the square root
  typedef struct packed {
    logic                          deg;
    logic [2:0]                    neg;
    logic [2:0][NORM_BITS-1:0]     m;
  } meta_t;

endpackage

@@ rtl/triangle_face_normal.sv @@
// triangle face normal: edge cross product, block normalize, isqrt, divide
// throughput: one triangle per cycle when not stalled; the 31-step square
// root and the 15-step divider each unroll into one register stage per step
// a stall on a valid result word freezes every stage; nothing is dropped
// reset (rst_n, synchronous, active low) clears all valid bits only
module triangle_face_normal (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p0_x,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p0_y,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p0_z,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p1_x,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p1_y,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p1_z,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p2_x,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p2_y,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] in_p2_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tfn_pkg::OUT_W-1:0]      out_normal_x,
  output logic signed [tfn_pkg::OUT_W-1:0]      out_normal_y,
  output logic signed [tfn_pkg::OUT_W-1:0]      out_normal_z,
  output logic                                  out_degenerate
);

  localparam int DW = tfn_pkg::DIFF_W;
  localparam int PW = tfn_pkg::PROD_W;
  localparam int CW = tfn_pkg::CROSS_W;
  localparam int MW = tfn_pkg::MAG_W;
  localparam int NB = tfn_pkg::NORM_BITS;
  localparam int RW = tfn_pkg::ROOT_W;
  localparam int QW = tfn_pkg::Q_W;
  localparam int EW = tfn_pkg::DREM_W;
  localparam int OW = tfn_pkg::OUT_W;

  // whole pipeline moves together unless the final word is held
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // valid bits
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  logic vs_r [RW];
  logic vq_r [QW];
  logic out_valid_r;

  // stage a: edge vectors
  logic signed [DW-1:0] d1_r [3], d2_r [3];
  // stage b: products
  logic signed [PW-1:0] pr_r [6];
  // stage c: cross components
  logic signed [CW-1:0] cr_r [3];
  // stage d: sign and magnitude
  logic [MW-1:0] mg_r [3], mge_r [3];
  logic [2:0]    ng_r, nge_r;
  // stage e: bit length of largest magnitude
  logic [tfn_pkg::BL_W-1:0] bl_r;
  // stage f..h
  tfn_pkg::meta_t mf_r, mg2_r, mh_r;
  logic [tfn_pkg::SQ_W-1:0] sq_r [3];
  logic [tfn_pkg::X_W-1:0]  xh_r;
  // square root steps
  logic [tfn_pkg::REM_W-1:0] sr_rem_r [RW], sr_rem_nxt [RW];
  logic [RW-1:0]             sr_root_r [RW], sr_root_nxt [RW];
  logic [tfn_pkg::X_W-1:0]   sr_x_r [RW], sr_x_nxt [RW];
  tfn_pkg::meta_t            sr_meta_r [RW];
  // divider steps
  logic [EW-1:0] dv_rem_r [QW][3], dv_rem_nxt [QW][3];
  logic [QW-1:0] dv_q_r [QW][3], dv_q_nxt [QW][3];
  logic [RW-1:0] dv_den_r [QW];
  logic [2:0]    dv_neg_r [QW];
  logic          dv_deg_r [QW];
  // output word
  logic signed [OW-1:0] on_r [3], on_nxt [3];
  logic                 odeg_r;

  // front-end combinational values
  logic signed [DW-1:0] d1_nxt [3], d2_nxt [3];
  logic signed [PW-1:0] pr_nxt [6];
  logic signed [CW-1:0] cr_nxt [3];
  logic signed [CW-1:0] ab_tmp [3];
  logic [MW-1:0]        mg_nxt [3];
  logic [MW-1:0]        or_v;
  logic [tfn_pkg::BL_W-1:0] bl_nxt;
  logic [MW+NB-1:0]     sh_tmp [3];
  tfn_pkg::meta_t       mf_nxt;
  logic [tfn_pkg::SUM_W-1:0] sum_v;

  // edges p1-p0 and p2-p1
  always_comb begin
    d1_nxt[0] = DW'(in_p1_x) - DW'(in_p0_x);
    d1_nxt[1] = DW'(in_p1_y) - DW'(in_p0_y);
    d1_nxt[2] = DW'(in_p1_z) - DW'(in_p0_z);
    d2_nxt[0] = DW'(in_p2_x) - DW'(in_p1_x);
    d2_nxt[1] = DW'(in_p2_y) - DW'(in_p1_y);
    d2_nxt[2] = DW'(in_p2_z) - DW'(in_p1_z);
  end

  // six partial products of the cross product
  always_comb begin
    pr_nxt[0] = PW'(d1_r[1]) * PW'(d2_r[2]);
    pr_nxt[1] = PW'(d1_r[2]) * PW'(d2_r[1]);
    pr_nxt[2] = PW'(d1_r[2]) * PW'(d2_r[0]);
    pr_nxt[3] = PW'(d1_r[0]) * PW'(d2_r[2]);
    pr_nxt[4] = PW'(d1_r[0]) * PW'(d2_r[1]);
    pr_nxt[5] = PW'(d1_r[1]) * PW'(d2_r[0]);
    for (int i = 0; i < 3; i++) begin
      cr_nxt[i] = CW'(pr_r[2*i]) - CW'(pr_r[2*i+1]);
    end
  end

  // magnitudes, leading one, block shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab_tmp[i] = -cr_r[i];
      mg_nxt[i] = cr_r[i][CW-1] ? ab_tmp[i][MW-1:0] : cr_r[i][MW-1:0];
    end
    or_v   = mg_r[0] | mg_r[1] | mg_r[2];
    bl_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_v[i]) bl_nxt = tfn_pkg::BL_W'(i + 1);
    end
    for (int i = 0; i < 3; i++) begin
      sh_tmp[i]    = {mge_r[i], {NB{1'b0}}} >> bl_r;
      mf_nxt.m[i]  = sh_tmp[i][NB-1:0];
    end
    mf_nxt.neg = nge_r;
    mf_nxt.deg = (bl_r == '0);
    sum_v = tfn_pkg::SUM_W'(sq_r[0]) + tfn_pkg::SUM_W'(sq_r[1])
          + tfn_pkg::SUM_W'(sq_r[2]);
  end

  // one square root digit per stage
  always_comb begin
    logic [tfn_pkg::REM_W-1:0] rin, r2, trial;
    logic [RW-1:0]             root_in;
    logic [tfn_pkg::X_W-1:0]   xin;
    for (int i = 0; i < RW; i++) begin
      rin     = (i == 0) ? '0 : sr_rem_r[(i == 0) ? 0 : i-1];
      root_in = (i == 0) ? '0 : sr_root_r[(i == 0) ? 0 : i-1];
      xin     = (i == 0) ? xh_r : sr_x_r[(i == 0) ? 0 : i-1];
      r2      = {rin[tfn_pkg::REM_W-3:0], xin[tfn_pkg::X_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      sr_x_nxt[i] = {xin[tfn_pkg::X_W-3:0], 2'b00};
      if (r2 >= trial) begin
        sr_rem_nxt[i]  = r2 - trial;
        sr_root_nxt[i] = {root_in[RW-2:0], 1'b1};
      end else begin
        sr_rem_nxt[i]  = r2;
        sr_root_nxt[i] = {root_in[RW-2:0], 1'b0};
      end
    end
  end

  // one quotient bit per stage for each of the three lanes
  always_comb begin
    logic [EW-1:0] rin, dsh;
    logic [QW-1:0] qin;
    logic [RW-1:0] den;
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          den = sr_root_r[RW-1];
          rin = EW'({sr_meta_r[RW-1].m[l], {(tfn_pkg::RT_SHIFT +
                tfn_pkg::NORMAL_FRAC_BITS){1'b0}}}) + EW'(den >> 1);
          qin = '0;
        end else begin
          den = dv_den_r[(j == 0) ? 0 : j-1];
          rin = dv_rem_r[(j == 0) ? 0 : j-1][l];
          qin = dv_q_r[(j == 0) ? 0 : j-1][l];
        end
        dsh = EW'(den) << (QW - 1 - j);
        if (rin >= dsh) begin
          dv_rem_nxt[j][l] = rin - dsh;
          dv_q_nxt[j][l]   = {qin[QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][l] = rin;
          dv_q_nxt[j][l]   = {qin[QW-2:0], 1'b0};
        end
      end
    end
  end

  // clamp, sign, degenerate override
  always_comb begin
    logic [QW-1:0] n;
    for (int l = 0; l < 3; l++) begin
      n = dv_q_r[QW-1][l];
      if (n > QW'(1 << tfn_pkg::NORMAL_FRAC_BITS)) begin
        n = QW'(1 << tfn_pkg::NORMAL_FRAC_BITS);
      end
      if (dv_deg_r[QW-1]) on_nxt[l] = '0;
      else if (dv_neg_r[QW-1][l]) on_nxt[l] = -OW'(n);
      else on_nxt[l] = OW'(n);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0;
      ve_r <= 1'b0; vf_r <= 1'b0; vg_r <= 1'b0; vh_r <= 1'b0;
      for (int i = 0; i < RW; i++) vs_r[i] <= 1'b0;
      for (int j = 0; j < QW; j++) vq_r[j] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
      ve_r <= vd_r; vf_r <= ve_r; vg_r <= vf_r; vh_r <= vg_r;
      vs_r[0] <= vh_r;
      for (int i = 1; i < RW; i++) vs_r[i] <= vs_r[i-1];
      vq_r[0] <= vs_r[RW-1];
      for (int j = 1; j < QW; j++) vq_r[j] <= vq_r[j-1];
      out_valid_r <= vq_r[QW-1];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      pr_r <= pr_nxt;
      cr_r <= cr_nxt;
      mg_r <= mg_nxt;
      for (int i = 0; i < 3; i++) ng_r[i] <= cr_r[i][CW-1];
      mge_r <= mg_r;
      nge_r <= ng_r;
      bl_r  <= bl_nxt;
      mf_r  <= mf_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= tfn_pkg::SQ_W'(mf_r.m[i]) * tfn_pkg::SQ_W'(mf_r.m[i]);
      end
      mg2_r <= mf_r;
      xh_r  <= tfn_pkg::X_W'({sum_v, {NB{1'b0}}});
      mh_r  <= mg2_r;
      sr_rem_r  <= sr_rem_nxt;
      sr_root_r <= sr_root_nxt;
      sr_x_r    <= sr_x_nxt;
      sr_meta_r[0] <= mh_r;
      for (int i = 1; i < RW; i++) sr_meta_r[i] <= sr_meta_r[i-1];
      dv_rem_r <= dv_rem_nxt;
      dv_q_r   <= dv_q_nxt;
      dv_den_r[0] <= sr_root_r[RW-1];
      dv_neg_r[0] <= sr_meta_r[RW-1].neg;
      dv_deg_r[0] <= sr_meta_r[RW-1].deg;
      for (int j = 1; j < QW; j++) begin
        dv_den_r[j] <= dv_den_r[j-1];
        dv_neg_r[j] <= dv_neg_r[j-1];
        dv_deg_r[j] <= dv_deg_r[j-1];
      end
      on_r   <= on_nxt;
      odeg_r <= dv_deg_r[QW-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_normal_x   = on_r[0];
  assign out_normal_y   = on_r[1];
  assign out_normal_z   = on_r[2];
  assign out_degenerate = odeg_r;

endmodule

@@ tb/sv/triangle_face_normal_test.sv @@
// testbench for the triangle face normal block: predicted normals checked word by word
module triangle_face_normal_test;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               deg;
  } normal_t;

  int unsigned errors = 0;

  // mismatch report
  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // rounded fixed-point unit normal of one triangle
  function automatic normal_t face_normal(input logic signed [15:0] p[9]);
    logic signed [16:0] e1[3], e2[3];
    logic signed [35:0] c[3];
    logic [34:0] cm[3];
    logic [63:0] m[3], s, r, n, rem, bit_v;
    int bl, sr, sl, i, b;
    normal_t res;
    for (i = 0; i < 3; i++) begin
      e1[i] = 17'(p[3+i]) - 17'(p[i]);
      e2[i] = 17'(p[6+i]) - 17'(p[3+i]);
    end
    c[0] = 36'(e1[1]) * 36'(e2[2]) - 36'(e1[2]) * 36'(e2[1]);
    c[1] = 36'(e1[2]) * 36'(e2[0]) - 36'(e1[0]) * 36'(e2[2]);
    c[2] = 36'(e1[0]) * 36'(e2[1]) - 36'(e1[1]) * 36'(e2[0]);
    bl = 0;
    for (i = 0; i < 3; i++) begin
      cm[i] = c[i] < 0 ? 35'(-c[i]) : 35'(c[i]);
      b = 0;
      while (b < 35 && (cm[i] >> b) != 0) b++;
      if (b > bl) bl = b;
    end
    if (bl == 0) begin
      res = '{0, 0, 0, 1'b1};
      return res;
    end
    sr = bl > tfn_pkg::NORM_BITS ? bl - tfn_pkg::NORM_BITS : 0;
    sl = bl > tfn_pkg::NORM_BITS ? 0 : tfn_pkg::NORM_BITS - bl;
    s = 0;
    for (i = 0; i < 3; i++) begin
      m[i] = (64'(cm[i]) >> sr) << sl;
      s += m[i] * m[i];
    end
    // bitwise integer square root
    rem = s << tfn_pkg::NORM_BITS;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= r + bit_v) begin
        rem -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else r >>= 1;
      bit_v >>= 2;
    end
    for (i = 0; i < 3; i++) begin
      n = ((m[i] << (tfn_pkg::NORMAL_FRAC_BITS + 10)) + (r >> 1)) / r;
      if (n > (64'd1 << tfn_pkg::NORMAL_FRAC_BITS)) n = 64'd1 << tfn_pkg::NORMAL_FRAC_BITS;
      if (c[i] < 0) n = -n;
      if (i == 0) res.nx = n[15:0];
      else if (i == 1) res.ny = n[15:0];
      else res.nz = n[15:0];
    end
    res.deg = 1'b0;
    return res;
  endfunction

  class normal_scoreboard;
    normal_t pending[$];
    int unsigned checked = 0;
    int unsigned flat = 0;

    function void note_triangle(logic signed [15:0] p[9]);
      pending = {pending, face_normal(p)};
    endfunction

    task check_normal(normal_t got);
      normal_t want;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.deg) flat++;
      if (got.nx !== want.nx)
        report($sformatf("normal_x got %0d want %0d", got.nx, want.nx));
      if (got.ny !== want.ny)
        report($sformatf("normal_y got %0d want %0d", got.ny, want.ny));
      if (got.nz !== want.nz)
        report($sformatf("normal_z got %0d want %0d", got.nz, want.nz));
      if (got.deg !== want.deg)
        report($sformatf("degenerate got %0b want %0b", got.deg, want.deg));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid, out_degenerate;
  logic signed [15:0] in_p0_x = 0, in_p0_y = 0, in_p0_z = 0;
  logic signed [15:0] in_p1_x = 0, in_p1_y = 0, in_p1_z = 0;
  logic signed [15:0] in_p2_x = 0, in_p2_y = 0, in_p2_z = 0;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  normal_scoreboard sb = new();
  int unsigned cycles = 0;
  bit stim_done = 0;

  triangle_face_normal dut (.*);

  // clock and cycle limit
  initial begin
    forever begin
      #1 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > 200000) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // one word onto the input channel
  task automatic send(input logic signed [15:0] p[9]);
    in_valid <= 1'b1;
    {in_p0_x, in_p0_y, in_p0_z} <= {p[0], p[1], p[2]};
    {in_p1_x, in_p1_y, in_p1_z} <= {p[3], p[4], p[5]};
    {in_p2_x, in_p2_y, in_p2_z} <= {p[6], p[7], p[8]};
    do @(posedge clk); while (in_stall);
    sb.note_triangle(p);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random triangle: wide, small-scale, collinear, or full-range corners
  task automatic random_triangle(output logic signed [15:0] p[9]);
    int k = $urandom_range(0, 9);
    int i;
    for (i = 0; i < 9; i++) p[i] = 16'($urandom);
    if (k < 3) begin
      for (i = 3; i < 9; i++) p[i] = p[i % 3] + 16'($signed($urandom_range(0, 15)) - 8);
    end else if (k == 3) begin
      for (i = 0; i < 3; i++) begin
        p[3+i] = p[i] + 16'($urandom_range(0, 200));
        p[6+i] = p[3+i] + (p[3+i] - p[i]);
      end
    end else if (k == 4) begin
      for (i = 0; i < 9; i++) p[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
  endtask

  // stimulus
  initial begin
    logic signed [15:0] p[9];
    int i, j;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, axis planes, degenerate cases
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send(p);
    p = '{0, 0, 0, 4096, 0, 0, 4096, 4096, 0};
    send(p);
    p = '{0, 0, 0, 0, 4096, 0, 0, 4096, 4096};
    send(p);
    p = '{0, 0, 0, 0, 0, 4096, 4096, 0, 4096};
    send(p);
    p = '{-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
    send(p);
    p = '{32767, 32767, 32767, -32768, 32767, -32768, -32768, -32768, 32767};
    send(p);
    p = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0};
    send(p);
    p = '{1, 1, 1, 2, 2, 2, 3, 3, 3};
    send(p);
    p = '{5, 5, 5, 5, 5, 5, 9, 0, 2};
    send(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send(p);
    p = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};
    send(p);
    p = '{100, -200, 300, 100, -200, 300, 100, -200, 300};
    send(p);
    p = '{-32768, -32768, 0, 32767, 32767, 0, -32768, 32767, 0};
    send(p);
    // random part, with one full drain midway
    for (i = 0; i < 800; i++) begin
      random_triangle(p);
      if (i == 400) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (i < 100 || i >= 700) j = 0;
      else j = $urandom_range(0, 9);
      gap(j);
      send(p);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // result side: stall draws and checking
  initial begin
    int hold;
    normal_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_normal_x, out_normal_y, out_normal_z, out_degenerate};
        sb.check_normal(got);
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold = (cycles % 3000 < 1000) ? 0 : $urandom_range(0, 9);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d triangles, %0d degenerate, full-range and collinear cases",
             sb.checked, sb.flat);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
